// ===== sv/sbae_pkg.sv =====
`default_nettype none
package sbae_pkg;

	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;
	localparam int SIX_W  = 6;
	localparam logic [CHAR_W-1:0] CHAR_BIAS = 7'h20;

	// position of the next byte within its group of three
	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [CHAR_W-1:0] chr;
		logic              last;
	} res_t;

	// results of one byte: r0 always, r1 when two is set
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} pair_t;

	function automatic logic [CHAR_W-1:0] to_char(input logic [SIX_W-1:0] v);
		return {1'b0, v} + CHAR_BIAS;
	endfunction

endpackage
`default_nettype wire

// ===== sv/six_bit_ascii_offset_encoder.sv =====
// Three-to-four printable character encoder, uuencode style, no padding.
// Each slave transaction carries one source byte (tdata) and an end-of-stream
// mark (tlast); each master transaction carries one character, the six-bit
// value plus 0x20 (range 0x20..0x5F), with tlast on the final character of
// the stream. Bytes one and two of a group give one character each, byte
// three gives two; a byte one or two with tlast also flushes the leftover
// bits as one more character, and the group state then returns to the start.
// Rate: one byte per cycle while each byte yields one character and m_tready
// holds; a byte that yields two holds up the next, as the single master port,
// one character per cycle, sets the pace. A byte passes the input register
// and then the output queue before its first character. An input register
// lets the next byte be taken while characters still wait on the master side.
`default_nettype none
module six_bit_ascii_offset_encoder
	import sbae_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // in_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,   // [6:0] out_char, [7] zero
	output logic            m_tlast    // out_last
);

	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              valid_s1;
	logic              load;
	pair_t             pair;
	res_t              out_res;

	// input register: refills in the cycle it hands its byte to the queue
	assign s_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// group phase and carried bits advance as the byte's characters are queued
	sbae_encode u_encode (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.advance (load),
		.pair    (pair)
	);

	sbae_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair),
		.pair_valid (valid_s1),
		.load       (load),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (out_res)
	);

	assign m_tdata = {1'b0, out_res.chr};
	assign m_tlast = out_res.last;

endmodule
`default_nettype wire

// ===== sv/sbae_encode.sv =====
`default_nettype none
module sbae_encode
	import sbae_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              in_last,
	input  wire logic              advance,
	output pair_t                  pair
);

	phase_t     phase_q, phase_nx;
	logic [3:0] carry_q, carry_nx;

	always_comb begin
		pair     = '0;
		phase_nx = phase_q;
		carry_nx = carry_q;
		case (phase_q)
			PH_SECOND: begin
				pair.r0.chr  = to_char({carry_q[1:0], in_byte[7:4]});
				pair.r1.chr  = to_char({in_byte[3:0], 2'b00});
				pair.r1.last = in_last;
				pair.two     = in_last;
				carry_nx     = in_byte[3:0];
				phase_nx     = PH_THIRD;
			end
			PH_THIRD: begin
				pair.r0.chr  = to_char({carry_q, in_byte[7:6]});
				pair.r1.chr  = to_char(in_byte[5:0]);
				pair.r1.last = in_last;
				pair.two     = 1'b1;
				carry_nx     = '0;
				phase_nx     = PH_FIRST;
			end
			default: begin
				pair.r0.chr  = to_char(in_byte[7:2]);
				pair.r1.chr  = to_char({in_byte[1:0], 4'b0000});
				pair.r1.last = in_last;
				pair.two     = in_last;
				carry_nx     = {2'b00, in_byte[1:0]};
				phase_nx     = PH_SECOND;
			end
		endcase
		if (in_last) begin
			carry_nx = '0;
			phase_nx = PH_FIRST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			carry_q <= '0;
		end else if (advance) begin
			phase_q <= phase_nx;
			carry_q <= carry_nx;
		end
	end

endmodule
`default_nettype wire

// ===== sv/sbae_outq.sv =====
`default_nettype none
module sbae_outq
	import sbae_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire pair_t pair,
	input  wire logic  pair_valid,
	output logic       load,
	output logic       out_valid,
	input  wire logic  out_ready,
	output res_t       out_res
);

	logic [1:0] cnt_q;
	res_t       slot0_q, slot1_q;
	logic       fire;

	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = slot0_q;
	assign fire      = out_valid && out_ready;
	// room for a new pair once the queue drains this cycle
	assign load      = pair_valid && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && fire));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= pair.two ? 2'd2 : 2'd1;
		end else if (fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= pair.r0;
			slot1_q <= pair.r1;
		end else if (fire) begin
			slot0_q <= slot1_q;
		end
	end

endmodule
`default_nettype wire
